// ===== rtl/core/drrb_pkg.sv =====
package drrb_pkg;

	localparam logic [15:0] LEVEL_MAX = 16'hFFFF;
	localparam logic [15:0] DEVICE_CODE_RESET = 16'h0001;
	// one past the last holding register
	localparam logic [16:0] REG_LIMIT = 17'd4;
	localparam logic [15:0] INPUT_REG_ADDR = 16'd1;
	localparam logic [2:0] INPUT_REG_COUNT = 3'd1;
	localparam int NUM_HOLD = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int MAX_BURST = 3;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_READ_HOLD = 2'd1,
		FUNC_WRITE_HOLD = 2'd2,
		FUNC_READ_INPUT = 2'd3
	} func_t;

	typedef struct packed {
		logic status;
		logic [15:0] read_value;
		logic last;
		logic [15:0] pwm_compare;
		logic pwm_running;
	} res_t;

endpackage

// ===== rtl/core/dimmer_ramp_register_block_top.sv =====
// PWM dimmer register block. Holding registers 1..3 are current level, target level and ramp
// step; input register 1 returns the device code. A new input word can be accepted every cycle
// while in_ready is high: the state update and all results of a word are computed in the
// accept cycle and pushed into a 4-deep result queue, which drains one result word per cycle
// while out_ready is high. A holding read of n registers gives n result words, so a run of
// such reads is paced by the queue drain; in_ready is high while at most one result waits.
module dimmer_ramp_register_block_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic [15:0] address,
	input logic [2:0] count,
	input logic [15:0] value_0,
	input logic [15:0] value_1,
	input logic [15:0] value_2,
	output logic out_valid,
	input logic out_ready,
	output logic status,
	output logic [15:0] read_value,
	output logic last,
	output logic [15:0] pwm_compare,
	output logic pwm_running
);

	logic [15:0] device_code_q;
	logic [15:0] hold_q [drrb_pkg::NUM_HOLD];
	logic [15:0] acc_q;
	logic [15:0] cmp_q;

	logic [15:0] hold_d [drrb_pkg::NUM_HOLD];
	logic [15:0] acc_d;
	logic [15:0] cmp_d;

	drrb_pkg::res_t fifo_q [drrb_pkg::FIFO_DEPTH];
	logic [drrb_pkg::PTR_W-1:0] wr_ptr_q;
	logic [drrb_pkg::PTR_W-1:0] rd_ptr_q;
	logic [drrb_pkg::CNT_W-1:0] cnt_q;

	drrb_pkg::res_t res [drrb_pkg::MAX_BURST];
	logic [1:0] n_res;
	logic [16:0] end_addr;
	logic bad;
	logic [16:0] acc_sum;
	logic [15:0] vals [drrb_pkg::NUM_HOLD];
	logic [15:0] level_now;
	logic [15:0] level_goal;
	logic [15:0] ramp_rate;
	logic accept;
	logic pop;
	drrb_pkg::res_t head;

	function automatic logic [15:0] hold_sel(input logic [15:0] h0, input logic [15:0] h1,
			input logic [15:0] h2, input logic [1:0] idx);
		logic [15:0] r;
		case (idx)
			2'd0: r = h0;
			2'd1: r = h1;
			2'd2: r = h2;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign level_now = hold_q[0];
	assign level_goal = hold_q[1];
	assign ramp_rate = hold_q[2];
	assign vals[0] = value_0;
	assign vals[1] = value_1;
	assign vals[2] = value_2;

	assign end_addr = {1'b0, address} + 17'(count);
	assign bad = (address == '0) || (end_addr > drrb_pkg::REG_LIMIT);
	assign acc_sum = {1'b0, acc_q} + {1'b0, ramp_rate};

	assign in_ready = (cnt_q <= drrb_pkg::CNT_W'(1));
	assign accept = in_valid && in_ready;
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;

	// next state
	always_comb begin
		logic [1:0] off;
		logic [16:0] reg_addr;
		off = '0;
		reg_addr = '0;
		hold_d = hold_q;
		acc_d = acc_q;
		cmp_d = cmp_q;
		unique case (drrb_pkg::func_t'(func))
			drrb_pkg::FUNC_TICK: begin
				if (level_now < level_goal) begin
					if (acc_sum[16]) begin
						hold_d[0] = level_now + 16'd1;
						cmp_d = level_now + 16'd1;
					end
					acc_d = acc_sum[15:0];
				end else if (level_now > level_goal) begin
					if (acc_q < ramp_rate) begin
						hold_d[0] = level_now - 16'd1;
						cmp_d = level_now - 16'd1;
					end
					acc_d = acc_q - ramp_rate;
				end
			end
			drrb_pkg::FUNC_WRITE_HOLD: begin
				if (!bad) begin
					for (int k = 0; k < drrb_pkg::NUM_HOLD; k++) begin
						reg_addr = 17'(k + 1);
						off = 2'(k + 1) - address[1:0];
						if ((17'(address) <= reg_addr) && (reg_addr < end_addr))
							hold_d[k] = hold_sel(vals[0], vals[1], vals[2], off);
					end
				end
			end
			drrb_pkg::FUNC_READ_HOLD, drrb_pkg::FUNC_READ_INPUT: begin
			end
			default: begin
			end
		endcase
	end

	// result words, carrying the state after this word
	always_comb begin
		logic [1:0] idx;
		idx = '0;
		n_res = 2'd1;
		for (int i = 0; i < drrb_pkg::MAX_BURST; i++) begin
			res[i].status = 1'b0;
			res[i].read_value = '0;
			res[i].last = 1'b1;
			res[i].pwm_compare = cmp_d;
			res[i].pwm_running = (hold_d[0] != drrb_pkg::LEVEL_MAX);
		end
		unique case (drrb_pkg::func_t'(func))
			drrb_pkg::FUNC_TICK: begin
			end
			drrb_pkg::FUNC_READ_INPUT: begin
				if (address == drrb_pkg::INPUT_REG_ADDR && count == drrb_pkg::INPUT_REG_COUNT)
					res[0].read_value = device_code_q;
				else
					res[0].status = 1'b1;
			end
			drrb_pkg::FUNC_WRITE_HOLD: begin
				res[0].status = bad;
			end
			drrb_pkg::FUNC_READ_HOLD: begin
				if (bad) begin
					res[0].status = 1'b1;
				end else if (count != '0) begin
					n_res = count[1:0];
					for (int i = 0; i < drrb_pkg::MAX_BURST; i++) begin
						idx = address[1:0] + 2'(i) - 2'd1;
						res[i].read_value = hold_sel(hold_q[0], hold_q[1], hold_q[2], idx);
						res[i].last = (3'(i + 1) == count);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_code_q <= drrb_pkg::DEVICE_CODE_RESET;
			hold_q[0] <= drrb_pkg::LEVEL_MAX;
			hold_q[1] <= drrb_pkg::LEVEL_MAX;
			hold_q[2] <= drrb_pkg::LEVEL_MAX;
			acc_q <= '0;
			cmp_q <= drrb_pkg::LEVEL_MAX;
		end else begin
			if (cfg_wr_en)
				device_code_q <= cfg_wr_data;
			if (accept) begin
				hold_q <= hold_d;
				acc_q <= acc_d;
				cmp_q <= cmp_d;
			end
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= wr_ptr_q + drrb_pkg::PTR_W'(n_res);
			if (pop)
				rd_ptr_q <= rd_ptr_q + drrb_pkg::PTR_W'(1);
			cnt_q <= cnt_q + (accept ? drrb_pkg::CNT_W'(n_res) : '0)
				- (pop ? drrb_pkg::CNT_W'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < drrb_pkg::MAX_BURST; i++) begin
			if (accept && (2'(i) < n_res))
				fifo_q[wr_ptr_q + drrb_pkg::PTR_W'(i)] <= res[i];
		end
	end

	assign head = fifo_q[rd_ptr_q];
	assign status = head.status;
	assign read_value = head.read_value;
	assign last = head.last;
	assign pwm_compare = head.pwm_compare;
	assign pwm_running = head.pwm_running;

endmodule
